/* src/dmpi_pkg.sv */
// Shared types, constants and the microcode ROM for the dual motor PI speed controller.
// Used by dmpi_csr, dmpi_sequencer, dmpi_datapath and the top level; depends on nothing.
package dmpi_pkg;

   // Fixed-point position of angles, speeds, target, error sum, cap and drive.
   localparam int FRACTION_BITS = 16;

   // Register indexes on the configuration port.
   localparam int CSR_INDEX_W = 3;
   localparam logic [CSR_INDEX_W-1:0] REG_PROPORTIONAL_GAIN  = 3'd0;
   localparam logic [CSR_INDEX_W-1:0] REG_INTEGRAL_GAIN      = 3'd1;
   localparam logic [CSR_INDEX_W-1:0] REG_SPEED_TARGET       = 3'd2;
   localparam logic [CSR_INDEX_W-1:0] REG_FILTER_COEFFICIENT = 3'd3;
   localparam logic [CSR_INDEX_W-1:0] REG_INTEGRAL_CAP       = 3'd4;

   // Register reset values.
   localparam logic [23:0] KP_RESET   = 24'd1114;
   localparam logic [23:0] KI_RESET   = 24'd30147;
   localparam logic [15:0] COEF_RESET = 16'd54613;
   localparam longint TARGET_FULL     = longint'(128) << FRACTION_BITS;
   localparam logic [31:0] TARGET_RESET =
      (TARGET_FULL > longint'(32'h7FFF_FFFF)) ? 32'h7FFF_FFFF : 32'(TARGET_FULL);
   localparam logic [30:0] CAP_RESET  = 31'(longint'(12) << FRACTION_BITS);

   // Full-scale drive of 12 V.
   localparam logic [31:0] DRIVE_MAX  = 32'(longint'(12) << FRACTION_BITS);

   // Arithmetic constants.
   localparam logic [31:0] ANGLE_SCALE = 32'd100;
   // Division by 100: bias the error by 100 * 2^26 so it is never negative, drop two
   // bits, then multiply by ceil(2^36 / 25) and keep bits above 36.
   localparam logic [34:0] DIV_OFFSET  = 35'(longint'(100) << 26);
   localparam logic [32:0] QUOT_BIAS   = 33'(longint'(1) << 26);
   localparam logic [31:0] RECIP_25    = 32'd2748779070;
   localparam int          RECIP_25_SHIFT = 36;
   // Division by 3 for the duty cycle: multiply by ceil(2^19 / 3), keep bits above 19.
   localparam logic [31:0] RECIP_3     = 32'd174763;
   localparam int          RECIP_3_SHIFT = 19;
   localparam logic [15:0] DUTY_MAX    = 16'hFFFF;
   localparam logic [31:0] INT32_MAX   = 32'h7FFF_FFFF;
   localparam logic [31:0] INT32_MIN   = 32'h8000_0000;

   // Configuration register file contents.
   typedef struct packed {
      logic [23:0]        kp;
      logic [23:0]        ki;
      logic signed [31:0] target;
      logic [15:0]        coef;
      logic [30:0]        cap;
   } cfg_type;

   // Microcode fields.
   typedef enum logic [0:0] {MA_T, MA_E} mul_a_sel_type;

   typedef enum logic [2:0] {
      MB_HUNDRED, MB_COEF, MB_RECIP25, MB_KP, MB_KI, MB_RECIP3
   } mul_b_sel_type;

   typedef enum logic [3:0] {
      ALU_NOP, ALU_ANGLE_DIFF, ALU_FILT_DIFF, ALU_FILT_UPD, ALU_ERR, ALU_OFFSET,
      ALU_QUOT, ALU_SUM, ALU_USED, ALU_HOLD, ALU_ACC, ALU_DRIVE, ALU_DUTY
   } alu_op_type;

   typedef enum logic [2:0] {
      SEQ_NEXT, SEQ_WAIT, SEQ_WHEEL, SEQ_EMIT, SEQ_JUMP
   } seq_op_type;

   localparam int PROG_LEN = 18;
   localparam int STEP_W   = $clog2(PROG_LEN);
   typedef logic [STEP_W-1:0] step_type;

   localparam step_type STEP_IDLE        = step_type'(0);
   localparam step_type STEP_WHEEL_START = step_type'(1);

   typedef struct packed {
      seq_op_type    seq;
      step_type      target;
      logic          mul_en;
      mul_a_sel_type mul_a;
      mul_b_sel_type mul_b;
      alu_op_type    alu;
   } ucode_type;

   // Control handed from the sequencer to the datapath.
   typedef struct packed {
      logic          mul_en;
      mul_a_sel_type mul_a;
      mul_b_sel_type mul_b;
      alu_op_type    alu;
      logic          wheel;
      logic          load;
      logic          emit;
   } dp_ctrl_type;

   // The program. Steps 1 to 16 run once for the front wheel and once for the rear.
   function automatic ucode_type ucode_rom(input step_type step);
      ucode_type w;
      w = '{seq: SEQ_NEXT, target: STEP_IDLE, mul_en: 1'b0, mul_a: MA_T,
            mul_b: MB_HUNDRED, alu: ALU_NOP};
      unique case (step)
         5'd0: begin
            w.seq = SEQ_WAIT;
         end
         5'd1:  w.alu = ALU_ANGLE_DIFF;
         5'd2: begin
            w.mul_en = 1'b1;
            w.mul_b  = MB_HUNDRED;
         end
         5'd3:  w.alu = ALU_FILT_DIFF;
         5'd4: begin
            w.mul_en = 1'b1;
            w.mul_b  = MB_COEF;
         end
         5'd5:  w.alu = ALU_FILT_UPD;
         5'd6:  w.alu = ALU_ERR;
         5'd7:  w.alu = ALU_OFFSET;
         5'd8: begin
            w.mul_en = 1'b1;
            w.mul_b  = MB_RECIP25;
         end
         5'd9:  w.alu = ALU_QUOT;
         5'd10: w.alu = ALU_SUM;
         5'd11: begin
            w.alu    = ALU_USED;
            w.mul_en = 1'b1;
            w.mul_a  = MA_E;
            w.mul_b  = MB_KP;
         end
         5'd12: begin
            w.alu    = ALU_HOLD;
            w.mul_en = 1'b1;
            w.mul_b  = MB_KI;
         end
         5'd13: w.alu = ALU_ACC;
         5'd14: w.alu = ALU_DRIVE;
         5'd15: begin
            w.mul_en = 1'b1;
            w.mul_b  = MB_RECIP3;
         end
         5'd16: begin
            w.alu    = ALU_DUTY;
            w.seq    = SEQ_WHEEL;
            w.target = STEP_WHEEL_START;
         end
         5'd17: begin
            w.seq    = SEQ_EMIT;
            w.target = STEP_IDLE;
         end
         default: begin
            w.seq    = SEQ_JUMP;
            w.target = STEP_IDLE;
         end
      endcase
      return w;
   endfunction

endpackage

/* src/dmpi_csr.sv */
// Configuration register file of the dual motor PI speed controller.
// Depends on dmpi_pkg for the register indexes, reset values and cfg_type.
module dmpi_csr (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               csr_valid,
   output logic                               csr_ready,
   input  logic [dmpi_pkg::CSR_INDEX_W-1:0]   csr_index,
   input  logic [31:0]                        csr_data,
   output dmpi_pkg::cfg_type                  cfg
);

   dmpi_pkg::cfg_type cfg_ff, cfg_in;

   assign csr_ready = 1'b1;
   assign cfg       = cfg_ff;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         unique case (csr_index)
            dmpi_pkg::REG_PROPORTIONAL_GAIN:  cfg_in.kp     = csr_data[23:0];
            dmpi_pkg::REG_INTEGRAL_GAIN:      cfg_in.ki     = csr_data[23:0];
            dmpi_pkg::REG_SPEED_TARGET:       cfg_in.target = csr_data;
            dmpi_pkg::REG_FILTER_COEFFICIENT: cfg_in.coef   = csr_data[15:0];
            dmpi_pkg::REG_INTEGRAL_CAP:       cfg_in.cap    = csr_data[30:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.kp     <= dmpi_pkg::KP_RESET;
         cfg_ff.ki     <= dmpi_pkg::KI_RESET;
         cfg_ff.target <= dmpi_pkg::TARGET_RESET;
         cfg_ff.coef   <= dmpi_pkg::COEF_RESET;
         cfg_ff.cap    <= dmpi_pkg::CAP_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule

/* src/dmpi_sequencer.sv */
// Microcode sequencer: step counter, wheel flag and ROM lookup of the control word.
// Depends on dmpi_pkg for the program, the control word and the datapath control struct.
module dmpi_sequencer (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  logic                  rsp_valid,
   input  logic                  rsp_ready,
   output dmpi_pkg::dp_ctrl_type ctrl
);

   dmpi_pkg::step_type  step_ff, step_in;
   logic                wheel_ff, wheel_in;
   dmpi_pkg::ucode_type cw;
   logic                out_free;

   assign cw       = dmpi_pkg::ucode_rom(step_ff);
   assign out_free = !rsp_valid || rsp_ready;

   // Next step and wheel.
   always_comb begin
      step_in  = step_ff + dmpi_pkg::step_type'(1);
      wheel_in = wheel_ff;
      unique case (cw.seq)
         dmpi_pkg::SEQ_NEXT: ;
         dmpi_pkg::SEQ_WAIT: begin
            if (req_valid) begin
               wheel_in = 1'b0;
            end else begin
               step_in = step_ff;
            end
         end
         dmpi_pkg::SEQ_WHEEL: begin
            if (!wheel_ff) begin
               step_in  = cw.target;
               wheel_in = 1'b1;
            end
         end
         dmpi_pkg::SEQ_EMIT: begin
            step_in = out_free ? cw.target : step_ff;
         end
         dmpi_pkg::SEQ_JUMP: step_in = cw.target;
         default: step_in = cw.target;
      endcase
   end

   // Handshake and datapath control.
   always_comb begin
      req_ready   = (cw.seq == dmpi_pkg::SEQ_WAIT);
      ctrl.load   = req_ready && req_valid;
      ctrl.emit   = (cw.seq == dmpi_pkg::SEQ_EMIT) && out_free;
      ctrl.mul_en = cw.mul_en;
      ctrl.mul_a  = cw.mul_a;
      ctrl.mul_b  = cw.mul_b;
      ctrl.alu    = cw.alu;
      ctrl.wheel  = wheel_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         step_ff  <= dmpi_pkg::STEP_IDLE;
         wheel_ff <= 1'b0;
      end else begin
         step_ff  <= step_in;
         wheel_ff <= wheel_in;
      end
   end

   a_step_in_program: assert property (@(posedge clock) disable iff (reset)
      step_ff < dmpi_pkg::PROG_LEN)
      else $error("step counter left the program");

   a_accept_starts_front: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> (step_ff == dmpi_pkg::STEP_WHEEL_START && !wheel_ff))
      else $error("accepted transaction did not start the front wheel pass");

   a_wheel_switch: assert property (@(posedge clock) disable iff (reset)
      $rose(wheel_ff) |-> $past(cw.seq == dmpi_pkg::SEQ_WHEEL))
      else $error("wheel flag changed outside the wheel jump");

   a_emit_after_rear: assert property (@(posedge clock) disable iff (reset)
      ctrl.emit |-> wheel_ff)
      else $error("result emitted before the rear wheel pass");

endmodule

/* src/dmpi_datapath.sv */
// Datapath: per-wheel state, working registers, one shared multiplier, ALU, result register.
// Depends on dmpi_pkg for constants, cfg_type and the datapath control struct.
module dmpi_datapath (
   input  logic                  clock,
   input  logic                  reset,
   input  dmpi_pkg::dp_ctrl_type ctrl,
   input  dmpi_pkg::cfg_type     cfg,
   input  logic signed [31:0]    req_front_angle,
   input  logic signed [31:0]    req_rear_angle,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output logic [15:0]           rsp_front_pwm,
   output logic [15:0]           rsp_rear_pwm,
   output logic signed [31:0]    rsp_front_speed,
   output logic signed [31:0]    rsp_rear_speed
);

   // Latched angles of the transaction in progress.
   logic [31:0]        angle_front_ff, angle_front_in, angle_rear_ff, angle_rear_in;
   // Per-wheel state.
   logic [31:0]        prev_front_ff, prev_front_in, prev_rear_ff, prev_rear_in;
   logic signed [31:0] filt_front_ff, filt_front_in, filt_rear_ff, filt_rear_in;
   logic signed [31:0] sum_front_ff, sum_front_in, sum_rear_ff, sum_rear_in;
   // Working registers.
   logic signed [32:0] t_ff, t_in, e_ff, e_in;
   logic signed [64:0] p_ff, p_in;
   logic signed [57:0] acc_ff, acc_in;
   logic [15:0]        duty_front_ff, duty_front_in, duty_rear_ff, duty_rear_in;
   // Result register.
   logic               rsp_valid_ff, rsp_valid_in;
   logic [15:0]        rsp_front_pwm_ff, rsp_front_pwm_in;
   logic [15:0]        rsp_rear_pwm_ff, rsp_rear_pwm_in;
   logic signed [31:0] rsp_front_speed_ff, rsp_front_speed_in;
   logic signed [31:0] rsp_rear_speed_ff, rsp_rear_speed_in;

   // Current wheel.
   logic [31:0]        angle_cur, prev_cur;
   logic signed [31:0] filt_cur, sum_cur;

   // Multiplier.
   logic signed [32:0] mul_a;
   logic [31:0]        mul_b;
   logic signed [32:0] mul_b_s;
   logic signed [65:0] mul_full;

   // ALU results.
   logic [31:0]        angle_diff;
   logic [32:0]        filt_diff;
   logic [31:0]        filt_new;
   logic [32:0]        err_new;
   logic [34:0]        offset_sum;
   logic [32:0]        quot;
   logic [33:0]        sum_wide;
   logic [31:0]        sum_sat;
   logic [31:0]        used_val;
   logic               acc_pos;
   logic [41:0]        acc_hi;
   logic [31:0]        drive_val;
   logic [47:0]        z_wide;
   logic [17:0]        duty_q;
   logic [15:0]        duty_val;

   assign angle_cur = ctrl.wheel ? angle_rear_ff : angle_front_ff;
   assign prev_cur  = ctrl.wheel ? prev_rear_ff  : prev_front_ff;
   assign filt_cur  = ctrl.wheel ? filt_rear_ff  : filt_front_ff;
   assign sum_cur   = ctrl.wheel ? sum_rear_ff   : sum_front_ff;

   always_comb begin
      mul_a = (ctrl.mul_a == dmpi_pkg::MA_E) ? e_ff : t_ff;
      unique case (ctrl.mul_b)
         dmpi_pkg::MB_HUNDRED: mul_b = dmpi_pkg::ANGLE_SCALE;
         dmpi_pkg::MB_COEF:    mul_b = {16'd0, cfg.coef};
         dmpi_pkg::MB_RECIP25: mul_b = dmpi_pkg::RECIP_25;
         dmpi_pkg::MB_KP:      mul_b = {8'd0, cfg.kp};
         dmpi_pkg::MB_KI:      mul_b = {8'd0, cfg.ki};
         dmpi_pkg::MB_RECIP3:  mul_b = dmpi_pkg::RECIP_3;
         default:              mul_b = '0;
      endcase
   end

   assign mul_b_s  = {1'b0, mul_b};
   assign mul_full = mul_a * mul_b_s;

   always_comb begin
      angle_diff = angle_cur - prev_cur;
      // Raw speed is the low word of the times-100 product.
      filt_diff  = {p_ff[31], p_ff[31:0]} - {filt_cur[31], filt_cur};
      // The arithmetic shift of the filter product floors; the new value fits 32 bits.
      filt_new   = filt_cur + p_ff[47:16];
      err_new    = {cfg.target[31], cfg.target} - {filt_cur[31], filt_cur};
      offset_sum = {{2{e_ff[32]}}, e_ff} + dmpi_pkg::DIV_OFFSET;
      quot       = {5'd0, p_ff[63:dmpi_pkg::RECIP_25_SHIFT]} - dmpi_pkg::QUOT_BIAS;

      sum_wide = {{2{sum_cur[31]}}, sum_cur} + {t_ff[32], t_ff};
      if (sum_wide[33:31] != 3'b000 && sum_wide[33:31] != 3'b111) begin
         sum_sat = sum_wide[33] ? dmpi_pkg::INT32_MIN : dmpi_pkg::INT32_MAX;
      end else begin
         sum_sat = sum_wide[31:0];
      end

      used_val = ($signed(sum_cur) > $signed({1'b0, cfg.cap})) ? {1'b0, cfg.cap} : sum_cur;

      acc_pos = !acc_ff[57] && (acc_ff != '0);
      acc_hi  = acc_ff[57:16];
      if (!acc_pos) begin
         drive_val = '0;
      end else if (acc_hi > 42'(dmpi_pkg::DRIVE_MAX)) begin
         drive_val = dmpi_pkg::DRIVE_MAX;
      end else begin
         drive_val = acc_hi[31:0];
      end
      // Scale drive to a quarter of 12 V full scale in Q.16; a divide by 3 follows.
      z_wide = {drive_val, 16'd0} >> (dmpi_pkg::FRACTION_BITS + 2);

      duty_q   = p_ff[dmpi_pkg::RECIP_3_SHIFT+17:dmpi_pkg::RECIP_3_SHIFT];
      duty_val = (duty_q[17:16] != 2'b00) ? dmpi_pkg::DUTY_MAX : duty_q[15:0];
   end

   always_comb begin
      angle_front_in = angle_front_ff;
      angle_rear_in  = angle_rear_ff;
      prev_front_in  = prev_front_ff;
      prev_rear_in   = prev_rear_ff;
      filt_front_in  = filt_front_ff;
      filt_rear_in   = filt_rear_ff;
      sum_front_in   = sum_front_ff;
      sum_rear_in    = sum_rear_ff;
      t_in           = t_ff;
      e_in           = e_ff;
      p_in           = ctrl.mul_en ? mul_full[64:0] : p_ff;
      acc_in         = acc_ff;
      duty_front_in  = duty_front_ff;
      duty_rear_in   = duty_rear_ff;

      if (ctrl.load) begin
         angle_front_in = req_front_angle;
         angle_rear_in  = req_rear_angle;
      end

      unique case (ctrl.alu)
         dmpi_pkg::ALU_NOP: ;
         dmpi_pkg::ALU_ANGLE_DIFF: begin
            t_in = {1'b0, angle_diff};
            if (ctrl.wheel) begin
               prev_rear_in = angle_cur;
            end else begin
               prev_front_in = angle_cur;
            end
         end
         dmpi_pkg::ALU_FILT_DIFF: t_in = filt_diff;
         dmpi_pkg::ALU_FILT_UPD: begin
            if (ctrl.wheel) begin
               filt_rear_in = filt_new;
            end else begin
               filt_front_in = filt_new;
            end
         end
         dmpi_pkg::ALU_ERR:    e_in = err_new;
         dmpi_pkg::ALU_OFFSET: t_in = {1'b0, offset_sum[33:2]};
         dmpi_pkg::ALU_QUOT:   t_in = quot;
         dmpi_pkg::ALU_SUM: begin
            if (ctrl.wheel) begin
               sum_rear_in = sum_sat;
            end else begin
               sum_front_in = sum_sat;
            end
         end
         dmpi_pkg::ALU_USED:  t_in = {used_val[31], used_val};
         dmpi_pkg::ALU_HOLD:  acc_in = p_ff[57:0];
         dmpi_pkg::ALU_ACC:   acc_in = acc_ff + p_ff[57:0];
         dmpi_pkg::ALU_DRIVE: t_in = {15'd0, z_wide[17:0]};
         dmpi_pkg::ALU_DUTY: begin
            if (ctrl.wheel) begin
               duty_rear_in = duty_val;
            end else begin
               duty_front_in = duty_val;
            end
         end
         default: ;
      endcase
   end

   always_comb begin
      rsp_valid_in       = rsp_valid_ff;
      rsp_front_pwm_in   = rsp_front_pwm_ff;
      rsp_rear_pwm_in    = rsp_rear_pwm_ff;
      rsp_front_speed_in = rsp_front_speed_ff;
      rsp_rear_speed_in  = rsp_rear_speed_ff;
      if (ctrl.emit) begin
         rsp_valid_in       = 1'b1;
         rsp_front_pwm_in   = duty_front_ff;
         rsp_rear_pwm_in    = duty_rear_ff;
         rsp_front_speed_in = filt_front_ff;
         rsp_rear_speed_in  = filt_rear_ff;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         prev_front_ff <= '0;
         prev_rear_ff  <= '0;
         filt_front_ff <= '0;
         filt_rear_ff  <= '0;
         sum_front_ff  <= '0;
         sum_rear_ff   <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         prev_front_ff <= prev_front_in;
         prev_rear_ff  <= prev_rear_in;
         filt_front_ff <= filt_front_in;
         filt_rear_ff  <= filt_rear_in;
         sum_front_ff  <= sum_front_in;
         sum_rear_ff   <= sum_rear_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      angle_front_ff     <= angle_front_in;
      angle_rear_ff      <= angle_rear_in;
      t_ff               <= t_in;
      e_ff               <= e_in;
      p_ff               <= p_in;
      acc_ff             <= acc_in;
      duty_front_ff      <= duty_front_in;
      duty_rear_ff       <= duty_rear_in;
      rsp_front_pwm_ff   <= rsp_front_pwm_in;
      rsp_rear_pwm_ff    <= rsp_rear_pwm_in;
      rsp_front_speed_ff <= rsp_front_speed_in;
      rsp_rear_speed_ff  <= rsp_rear_speed_in;
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_front_pwm   = rsp_front_pwm_ff;
   assign rsp_rear_pwm    = rsp_rear_pwm_ff;
   assign rsp_front_speed = rsp_front_speed_ff;
   assign rsp_rear_speed  = rsp_rear_speed_ff;

endmodule

/* src/dual_motor_pi_speed_control.sv */
// rsp_valid is registered; it rises after the emit step that follows the rear wheel pass.
// A new transaction is accepted only at the wait step, after the 16-step microprogram that the
// shared multiplier and ALU run once per wheel, plus one accept and one emit step, is through.
// A finished result waits in the output register while the next transaction is accepted.
// Reset (synchronous, active high) restores register defaults and clears all wheel state;
// there is no clearing pass.
// Depends on dmpi_pkg, dmpi_csr, dmpi_sequencer and dmpi_datapath.
module dual_motor_pi_speed_control (
   input  logic                              clock,
   input  logic                              reset,
   // Input channel: one transaction per control period.
   input  logic                              req_valid,
   output logic                              req_ready,
   input  logic signed [31:0]                req_front_angle,
   input  logic signed [31:0]                req_rear_angle,
   // Result channel.
   output logic                              rsp_valid,
   input  logic                              rsp_ready,
   output logic [15:0]                       rsp_front_pwm,
   output logic [15:0]                       rsp_rear_pwm,
   output logic signed [31:0]                rsp_front_speed,
   output logic signed [31:0]                rsp_rear_speed,
   // Configuration write channel.
   input  logic                              csr_valid,
   output logic                              csr_ready,
   input  logic [dmpi_pkg::CSR_INDEX_W-1:0]  csr_index,
   input  logic [31:0]                       csr_data
);

   // The register file holds gains, speed target, filter blend and integral cap. A write
   // to an index outside the register list is accepted and has no effect.
   dmpi_pkg::cfg_type     cfg;
   // Control word of the current microprogram step, decoded for the datapath.
   dmpi_pkg::dp_ctrl_type ctrl;

   dmpi_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .cfg       (cfg)
   );

   // The sequencer waits at step zero for a transaction, runs the wheel program for the
   // front wheel, jumps back to run it for the rear wheel, and then emits the result as
   // soon as the output register is free.
   dmpi_sequencer u_sequencer (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .ctrl      (ctrl)
   );

   // Per wheel the datapath forms the raw speed from the angle difference, low-pass
   // filters it, integrates the error with saturation, and turns the clamped PI drive
   // into a duty cycle. Divisions by 100 and by 12 are reciprocal multiplications on the
   // same multiplier.
   dmpi_datapath u_datapath (
      .clock           (clock),
      .reset           (reset),
      .ctrl            (ctrl),
      .cfg             (cfg),
      .req_front_angle (req_front_angle),
      .req_rear_angle  (req_rear_angle),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_front_pwm   (rsp_front_pwm),
      .rsp_rear_pwm    (rsp_rear_pwm),
      .rsp_front_speed (rsp_front_speed),
      .rsp_rear_speed  (rsp_rear_speed)
   );

endmodule

/* tb/tb_top.sv */
// Self-checking testbench for the dual motor PI speed controller.
// Drives the request, response and register-write channels; predicts each result in-line.
// Depends on dmpi_pkg and dual_motor_pi_speed_control.
module tb_top;
   timeunit 1ns;
   timeprecision 1ps;

   // One result carries both duty cycles and both filtered speeds.
   typedef struct {
      logic [15:0]        front_pwm;
      logic [15:0]        rear_pwm;
      logic signed [31:0] front_speed;
      logic signed [31:0] rear_speed;
   } duty_speed_type;

   typedef logic [dmpi_pkg::CSR_INDEX_W-1:0] reg_index_type;

   // Register defaults after reset, all in Q16.16 except the gains (Q8.16) and the
   // filter blend (Q0.16).
   localparam logic [23:0]        KP_DEFAULT     = 24'd1114;
   localparam logic [23:0]        KI_DEFAULT     = 24'd30147;
   localparam logic signed [31:0] TARGET_DEFAULT = 32'sd8388608;
   localparam logic [15:0]        COEF_DEFAULT   = 16'd54613;
   localparam logic [30:0]        CAP_DEFAULT    = 31'd786432;

   // Full-scale drive of 12 V and the limits of the 32-bit integrator.
   localparam longint FULL_DRIVE = 64'sd786432;
   localparam longint SUM_HI     = 64'sd2147483647;
   localparam longint SUM_LO     = -64'sd2147483648;

   // Angle advance in one 10 ms period that gives the default 128 rad/s.
   localparam logic [31:0] CRUISE_STEP = 32'd83886;
   // Angle advance whose speed, times 100, lands just inside the 32-bit range.
   localparam logic [31:0] FLAT_OUT_STEP = 32'd21474836;

   // Turnaround allowance per transaction; the end of the run waits twice that.
   localparam int LATENCY         = 34;
   localparam int HOLD_OFF_CYCLES = 400;
   localparam int WATCHDOG_LIMIT  = 20000;

   logic              clock           = 1'b0;
   logic              reset           = 1'b1;
   logic              req_valid       = 1'b0;
   logic              req_ready;
   logic [31:0]       req_front_angle = '0;
   logic [31:0]       req_rear_angle  = '0;
   logic              rsp_valid;
   logic              rsp_ready       = 1'b0;
   logic [15:0]       rsp_front_pwm;
   logic [15:0]       rsp_rear_pwm;
   logic signed [31:0] rsp_front_speed;
   logic signed [31:0] rsp_rear_speed;
   logic              csr_valid       = 1'b0;
   logic              csr_ready;
   reg_index_type     csr_index       = '0;
   logic [31:0]       csr_data        = '0;

   dual_motor_pi_speed_control i_dut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_front_angle (req_front_angle),
      .req_rear_angle  (req_rear_angle),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_front_pwm   (rsp_front_pwm),
      .rsp_rear_pwm    (rsp_rear_pwm),
      .rsp_front_speed (rsp_front_speed),
      .rsp_rear_speed  (rsp_rear_speed),
      .csr_valid       (csr_valid),
      .csr_ready       (csr_ready),
      .csr_index       (csr_index),
      .csr_data        (csr_data)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   // ------------------------------------------------------------------------------------
   // Controller shadow: our own copy of the registers and the per-wheel state. The
   // registers only change while the block is idle, so the result of a transaction can be
   // worked out the moment it is accepted.
   // ------------------------------------------------------------------------------------
   logic [23:0]        kp_gain     = KP_DEFAULT;
   logic [23:0]        ki_gain     = KI_DEFAULT;
   logic signed [31:0] speed_goal  = TARGET_DEFAULT;
   logic [15:0]        blend       = COEF_DEFAULT;
   logic [30:0]        windup_cap  = CAP_DEFAULT;

   logic [31:0]        front_angle_last = '0;
   logic [31:0]        rear_angle_last  = '0;
   logic signed [31:0] front_speed_avg  = '0;
   logic signed [31:0] rear_speed_avg   = '0;
   logic signed [31:0] front_integral   = '0;
   logic signed [31:0] rear_integral    = '0;

   // Results promised to the checker, oldest first.
   duty_speed_type pending_results[$];

   int items_sent      = 0;
   int results_checked = 0;
   int mismatches      = 0;
   int settings_count  = 0;

   // Handshake pacing. The sender percentage is read only by the stimulus process; the
   // receiver percentage and the hold-off count are read by the receiver process.
   int sender_idle_pct    = 0;
   int receiver_stall_pct = 0;
   int hold_off_requests  = 0;

   // Position of each wheel for the motion generator.
   logic [31:0] front_pos = '0;
   logic [31:0] rear_pos  = '0;

   // One wheel for one control period. Every shift and division floors, the speed and
   // the angle difference wrap at 32 bits, and the integrator saturates.
   function automatic void wheel_update(input logic [31:0] angle,
                                        inout logic [31:0] last,
                                        inout logic signed [31:0] avg,
                                        inout logic signed [31:0] integral,
                                        output logic [15:0] duty,
                                        output logic signed [31:0] speed);
      logic [31:0] raw;
      longint diff, smooth, err, quot, total, used, acc, drive, duty_full;
      raw = (angle - last) * 32'd100;
      diff = longint'($signed(raw)) - longint'(avg);
      last = angle;
      smooth = longint'(avg) + ((diff * longint'(blend)) >>> 16);
      avg = smooth[31:0];
      err = longint'(speed_goal) - longint'(avg);
      quot = err / 100;
      if (err % 100 < 0) quot = quot - 1;
      total = longint'(integral) + quot;
      if (total > SUM_HI) total = SUM_HI;
      else if (total < SUM_LO) total = SUM_LO;
      integral = total[31:0];
      // Only the copy that feeds the drive is capped; the stored sum keeps winding.
      used = (longint'(integral) > longint'(windup_cap)) ? longint'(windup_cap)
                                                         : longint'(integral);
      acc = err * longint'(kp_gain) + used * longint'(ki_gain);
      if (acc <= 0) begin
         drive = 0;
      end else begin
         drive = acc >>> 16;
         if (drive > FULL_DRIVE) drive = FULL_DRIVE;
      end
      duty_full = (drive <<< 16) / FULL_DRIVE;
      if (duty_full > 65535) duty_full = 65535;
      duty = duty_full[15:0];
      speed = avg;
   endfunction

   function automatic duty_speed_type predict_control_period(input logic [31:0] front,
                                                             input logic [31:0] rear);
      duty_speed_type r;
      wheel_update(front, front_angle_last, front_speed_avg, front_integral,
                   r.front_pwm, r.front_speed);
      wheel_update(rear, rear_angle_last, rear_speed_avg, rear_integral,
                   r.rear_pwm, r.rear_speed);
      return r;
   endfunction

   // Next wheel angle: mostly cruising near the target speed with jitter, sometimes a
   // jump to an arbitrary angle, a stop or a reversal.
   function automatic logic [31:0] next_wheel_angle(input logic [31:0] pos);
      int base, spread, pick;
      base = speed_goal / 100;
      spread = 4096 + ((base < 0) ? -base : base) / 8;
      pick = $urandom_range(99);
      if (pick < 80) return pos + 32'(base + int'($urandom_range(2 * spread)) - spread);
      if (pick < 90) return $urandom();
      if (pick < 95) return pos;
      return pos - 32'(base);
   endfunction

   // A register value: zero, the field's extremes, the default, a plausible value or
   // noise. Noise carries bits above the field width, which the block must drop.
   function automatic logic [31:0] pick_setting(input reg_index_type idx);
      logic [31:0] dflt, typical;
      case (idx)
         dmpi_pkg::REG_PROPORTIONAL_GAIN: begin
            dflt = KP_DEFAULT;
            typical = $urandom_range(262144);
         end
         dmpi_pkg::REG_INTEGRAL_GAIN: begin
            dflt = KI_DEFAULT;
            typical = $urandom_range(262144);
         end
         dmpi_pkg::REG_SPEED_TARGET: begin
            dflt = TARGET_DEFAULT;
            typical = $urandom_range(33554432);
         end
         dmpi_pkg::REG_FILTER_COEFFICIENT: begin
            dflt = COEF_DEFAULT;
            typical = $urandom_range(65535);
         end
         default: begin
            dflt = CAP_DEFAULT;
            typical = $urandom_range(4194304);
         end
      endcase
      case ($urandom_range(7))
         0: return 32'd0;
         1: return (idx == dmpi_pkg::REG_SPEED_TARGET) ? 32'h7FFF_FFFF : 32'hFFFF_FFFF;
         2: return (idx == dmpi_pkg::REG_SPEED_TARGET) ? 32'h8000_0000 : $urandom();
         3, 4: return dflt;
         5, 6: return typical;
         default: return $urandom();
      endcase
   endfunction

   // ------------------------------------------------------------------------------------
   // Channel drivers. Everything is driven right after a rising edge with nonblocking
   // assignments; a valid that stays high for the next transaction is simply reassigned.
   // ------------------------------------------------------------------------------------

   // One register-write transaction. The shadow copy is updated once it is accepted.
   // Indexes beyond the register file are dropped by the block and here too.
   task automatic write_reg(input reg_index_type idx, input logic [31:0] data);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= data;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      case (idx)
         dmpi_pkg::REG_PROPORTIONAL_GAIN:  kp_gain    = data[23:0];
         dmpi_pkg::REG_INTEGRAL_GAIN:      ki_gain    = data[23:0];
         dmpi_pkg::REG_SPEED_TARGET:       speed_goal = data;
         dmpi_pkg::REG_FILTER_COEFFICIENT: blend      = data[15:0];
         dmpi_pkg::REG_INTEGRAL_CAP:       windup_cap = data[30:0];
         default: ;
      endcase
   endtask

   // Writes all five registers. Only called with nothing in flight.
   task automatic program_controller(input logic [31:0] kp, input logic [31:0] ki,
                                     input logic [31:0] target, input logic [31:0] coef,
                                     input logic [31:0] cap);
      write_reg(dmpi_pkg::REG_PROPORTIONAL_GAIN, kp);
      write_reg(dmpi_pkg::REG_INTEGRAL_GAIN, ki);
      write_reg(dmpi_pkg::REG_SPEED_TARGET, target);
      write_reg(dmpi_pkg::REG_FILTER_COEFFICIENT, coef);
      write_reg(dmpi_pkg::REG_INTEGRAL_CAP, cap);
      csr_valid <= 1'b0;
      settings_count++;
   endtask

   task automatic program_random_setting();
      program_controller(pick_setting(dmpi_pkg::REG_PROPORTIONAL_GAIN),
                         pick_setting(dmpi_pkg::REG_INTEGRAL_GAIN),
                         pick_setting(dmpi_pkg::REG_SPEED_TARGET),
                         pick_setting(dmpi_pkg::REG_FILTER_COEFFICIENT),
                         pick_setting(dmpi_pkg::REG_INTEGRAL_CAP));
   endtask

   // One control-period transaction, with an optional idle gap in front of it. The
   // expected result is queued at the edge that accepts the transaction.
   task automatic send_angles(input logic [31:0] front, input logic [31:0] rear);
      if (sender_idle_pct != 0 && $urandom_range(99) < sender_idle_pct) begin
         req_valid <= 1'b0;
         do @(posedge clock); while ($urandom_range(99) < sender_idle_pct);
      end
      req_valid       <= 1'b1;
      req_front_angle <= front;
      req_rear_angle  <= rear;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      pending_results.push_back(predict_control_period(front, rear));
      items_sent++;
   endtask

   task automatic run_motion(input int count);
      for (int i = 0; i < count; i++) begin
         front_pos = next_wheel_angle(front_pos);
         rear_pos  = next_wheel_angle(rear_pos);
         send_angles(front_pos, rear_pos);
      end
   endtask

   // Stop offering and wait for every promised result. This is also the point where the
   // block is known to be idle, since each transaction gives exactly one result.
   task automatic wait_for_results();
      req_valid <= 1'b0;
      while (pending_results.size() != 0) @(posedge clock);
   endtask

   // ------------------------------------------------------------------------------------
   // Tests
   // ------------------------------------------------------------------------------------

   // Out of reset with default registers: a standing start, then cruising at the target
   // with the rear wheel slightly faster.
   task automatic test_default_tracking();
      send_angles(32'd0, 32'd0);
      for (int i = 1; i <= 5; i++)
         send_angles(32'(i) * CRUISE_STEP, 32'(i) * (CRUISE_STEP + 32'd1000));
      wait_for_results();
   endtask

   // Angle wrap in both directions across the signed boundary and through zero, the
   // field extremes, and alternating bit patterns.
   task automatic test_angle_extremes();
      send_angles(32'h7FFF_FFF0, 32'h8000_0010);
      send_angles(32'h8000_0010, 32'h7FFF_FFF0);
      send_angles(32'h7FFF_FFFF, 32'h8000_0000);
      send_angles(32'h8000_0000, 32'h7FFF_FFFF);
      send_angles(32'hFFFF_FFFF, 32'h0000_0000);
      send_angles(32'h0000_0000, 32'hFFFF_FFFF);
      send_angles(32'h5555_5555, 32'hAAAA_AAAA);
      wait_for_results();
   endtask

   // Largest proportional gain with the wheels standing still drives past 12 V and must
   // clamp to full duty; the most negative target then pulls the drive below zero, which
   // must give zero duty.
   task automatic test_drive_clamps();
      program_controller(32'hFFFF_FFFF, KI_DEFAULT, TARGET_DEFAULT, COEF_DEFAULT,
                         CAP_DEFAULT);
      for (int i = 0; i < 3; i++) send_angles(front_pos, rear_pos);
      wait_for_results();
      program_controller(32'hFFFF_FFFF, KI_DEFAULT, 32'h8000_0000, COEF_DEFAULT,
                         CAP_DEFAULT);
      for (int i = 0; i < 3; i++) send_angles(front_pos, rear_pos);
      wait_for_results();
   endtask

   // Writes to indexes past the last register must change nothing.
   task automatic test_unknown_register();
      for (int idx = int'(dmpi_pkg::REG_INTEGRAL_CAP) + 1; idx < (1 << dmpi_pkg::CSR_INDEX_W);
           idx++)
         write_reg(reg_index_type'(idx), $urandom());
      csr_valid <= 1'b0;
      run_motion(3);
      wait_for_results();
   endtask

   // All registers at zero, then all at their largest values.
   task automatic test_register_extremes();
      program_controller(32'd0, 32'd0, 32'd0, 32'd0, 32'd0);
      run_motion(20);
      wait_for_results();
      program_controller(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'h7FFF_FFFF, 32'hFFFF_FFFF,
                         32'hFFFF_FFFF);
      run_motion(20);
      wait_for_results();
   endtask

   // Drive both wheels flat out backwards against the largest target so the error sums
   // run into the positive limit, then flat out forwards against the most negative
   // target so they run into the negative limit. The filter passes the raw speed almost
   // unchanged, making each step add close to 2^32 / 100.
   task automatic test_integral_windup();
      program_controller($urandom(), $urandom(), 32'h7FFF_FFFF, 32'hFFFF, $urandom());
      for (int i = 0; i < 120; i++) begin
         front_pos = front_pos - FLAT_OUT_STEP + 32'($urandom_range(255));
         rear_pos  = rear_pos - FLAT_OUT_STEP + 32'($urandom_range(255));
         send_angles(front_pos, rear_pos);
      end
      wait_for_results();
      program_controller($urandom(), $urandom(), 32'h8000_0000, 32'hFFFF, $urandom());
      for (int i = 0; i < 120; i++) begin
         front_pos = front_pos + FLAT_OUT_STEP - 32'($urandom_range(255));
         rear_pos  = rear_pos + FLAT_OUT_STEP - 32'($urandom_range(255));
         send_angles(front_pos, rear_pos);
      end
      wait_for_results();
   endtask

   // Random motion under two random register settings, paced as given.
   task automatic test_random_traffic(input int idle_pct, input int stall_pct,
                                      input int count);
      sender_idle_pct = idle_pct;
      receiver_stall_pct <= stall_pct;
      for (int half = 0; half < 2; half++) begin
         program_random_setting();
         run_motion(count / 2);
         wait_for_results();
      end
   endtask

   // The receiver refuses results for a long stretch while transactions keep coming, so
   // the output register and the datapath fill and the block must hold off its input.
   task automatic test_output_backpressure();
      sender_idle_pct = 0;
      receiver_stall_pct <= 0;
      program_random_setting();
      hold_off_requests <= hold_off_requests + 1;
      run_motion(12);
      wait_for_results();
   endtask

   // ------------------------------------------------------------------------------------
   // Response side: pacing of rsp_ready, including the long hold-off.
   // ------------------------------------------------------------------------------------
   int hold_off_served = 0;
   int hold_left       = 0;

   always @(posedge clock) begin
      if (hold_off_served != hold_off_requests) begin
         hold_off_served <= hold_off_requests;
         hold_left <= HOLD_OFF_CYCLES;
         rsp_ready <= 1'b0;
      end else if (hold_left != 0) begin
         hold_left <= hold_left - 1;
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= (receiver_stall_pct == 0) || ($urandom_range(99) >= receiver_stall_pct);
      end
   end

   // ------------------------------------------------------------------------------------
   // Result checking. Each accepted result is compared with the oldest prediction.
   // ------------------------------------------------------------------------------------
   task automatic compare_field(input string label, input logic signed [63:0] want,
                                input logic signed [63:0] got);
      if (got !== want) begin
         $display("%0t ns: %s expected %0d, got %0d", $time, label, want, got);
         mismatches++;
      end
   endtask

   always @(posedge clock) begin : check_results
      duty_speed_type due;
      if (!reset && rsp_valid && rsp_ready) begin
         if (pending_results.size() == 0) begin
            $display("%0t ns: result transaction with nothing expected", $time);
            mismatches++;
         end else begin
            due = pending_results.pop_front();
            compare_field("front_pwm", due.front_pwm, rsp_front_pwm);
            compare_field("rear_pwm", due.rear_pwm, rsp_rear_pwm);
            compare_field("front_speed", due.front_speed, rsp_front_speed);
            compare_field("rear_speed", due.rear_speed, rsp_rear_speed);
            results_checked++;
         end
      end
   end

   // ------------------------------------------------------------------------------------
   // Watchdog: ends the run if no channel completes a transaction for too long.
   // ------------------------------------------------------------------------------------
   int quiet_cycles = 0;

   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready) ||
          (csr_valid && csr_ready)) begin
         quiet_cycles <= 0;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
         if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("%0t ns: no transaction for %0d cycles", $time, WATCHDOG_LIMIT);
            $display("dual_motor_pi_speed_control: mismatch");
            $finish;
         end
      end
   end

   // ------------------------------------------------------------------------------------
   // Test sequence. Directed checks first, then random traffic through each pacing phase:
   // none, idle sender, stalling receiver, and both; then the output back-pressure test.
   // ------------------------------------------------------------------------------------
   initial begin
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      test_default_tracking();
      test_angle_extremes();
      test_drive_clamps();
      test_unknown_register();

      test_register_extremes();
      test_integral_windup();
      test_random_traffic(0, 0, 230);
      test_random_traffic(51, 0, 230);
      test_random_traffic(0, 51, 230);
      test_random_traffic(37, 37, 230);
      test_output_backpressure();

      wait_for_results();
      repeat (2 * LATENCY) @(posedge clock);

      $display("Sent %0d control periods under %0d register settings, with idle, stall",
               items_sent, settings_count);
      $display("and hold-off phases; %0d results compared, %0d mismatches.",
               results_checked, mismatches);
      if (mismatches == 0 && pending_results.size() == 0)
         $display("dual_motor_pi_speed_control: match");
      else
         $display("dual_motor_pi_speed_control: mismatch");
      $finish;
   end

endmodule
